// File: hdl/dep_pkg.sv
// Shared types and constants for the encoded pointer decoder.
`timescale 1ns / 1ps
package dep_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned SHIFT_W = 7;
  localparam int unsigned FMT_W   = 4;

  localparam logic [FMT_W-1:0] FMT_ABSPTR = 4'h0;
  localparam logic [FMT_W-1:0] FMT_ULEB   = 4'h1;
  localparam logic [FMT_W-1:0] FMT_UDATA2 = 4'h2;
  localparam logic [FMT_W-1:0] FMT_UDATA4 = 4'h3;
  localparam logic [FMT_W-1:0] FMT_UDATA8 = 4'h4;
  localparam logic [FMT_W-1:0] FMT_SLEB   = 4'h9;
  localparam logic [FMT_W-1:0] FMT_SDATA2 = 4'ha;
  localparam logic [FMT_W-1:0] FMT_SDATA4 = 4'hb;
  localparam logic [FMT_W-1:0] FMT_SDATA8 = 4'hc;

  localparam logic [2:0] REL_PCREL = 3'h1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_req;
    logic [BYTE_W-1:0] encoding;
    logic [ADDR_W-1:0] position;
  } dep_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] value;
    logic [LEN_W-1:0]  length;
    logic              bad_format;
  } dep_result_t;

endpackage

// File: hdl/dep_byte_if.sv
// Channel carrying encoded stream bytes into the decoder.
`timescale 1ns / 1ps
interface dep_byte_if;
  import dep_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_req;
  logic [BYTE_W-1:0] encoding;
  logic [ADDR_W-1:0] position;

  modport source (output valid, data_byte, start_req, encoding, position, input ready);
  modport sink (input valid, data_byte, start_req, encoding, position, output ready);
endinterface

// File: hdl/dep_ptr_if.sv
// Channel carrying decoded pointers out of the decoder.
`timescale 1ns / 1ps
interface dep_ptr_if;
  import dep_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] value;
  logic [LEN_W-1:0]  length;
  logic              bad_format;

  modport source (output valid, value, length, bad_format, input ready);
  modport sink (input valid, value, length, bad_format, output ready);
endinterface

// File: hdl/dep_cfg_if.sv
// Write channel for the compatibility mode register.
`timescale 1ns / 1ps
interface dep_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/dwarf_encoded_pointer_decoder_unit.sv
// Top level of the encoded pointer decoder.
// A pointer's last byte goes through the input register, its result into the output register.
// Throughput: one byte per cycle, set by the single decode stage, while the output is free.
// An unknown format yields its result, with bad_format set, from its start transaction alone.
// Synchronous reset clears all decode state, the stage valid flags and the short pointer mode.
`timescale 1ns / 1ps
module dwarf_encoded_pointer_decoder_unit (
  input  logic      clk,
  input  logic      rst,
  dep_cfg_if.sink   cfg_wr,
  dep_byte_if.sink  byte_in,
  dep_ptr_if.source ptr_out
);
  import dep_pkg::*;

  logic        short_absptr;
  logic        item_valid;
  dep_item_t   item;
  logic        out_free;
  logic        advance;
  logic        res_valid;
  dep_result_t result;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_absptr <= 1'b0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      short_absptr <= cfg_wr.data;
    end
  end

  assign advance = item_valid && out_free;

  dep_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dep_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .short_absptr (short_absptr),
    .res_valid    (res_valid),
    .result       (result)
  );

  dep_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && res_valid),
    .result  (result),
    .free    (out_free),
    .ptr_out (ptr_out)
  );

endmodule

// File: hdl/dep_in_reg.sv
// Input register stage that holds one accepted byte transaction.
`timescale 1ns / 1ps
module dep_in_reg (
  input  logic              clk,
  input  logic              rst,
  dep_byte_if.sink          byte_in,
  input  logic              advance,
  output logic              item_valid,
  output dep_pkg::dep_item_t item
);
  import dep_pkg::*;

  logic take;

  assign byte_in.ready = !item_valid || advance;
  assign take          = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (take) begin
      item.data_byte <= byte_in.data_byte;
      item.start_req <= byte_in.start_req;
      item.encoding  <= byte_in.encoding;
      item.position  <= byte_in.position;
    end
  end

endmodule

// File: hdl/dep_core.sv
// Decode state and the per-byte accumulate, sign-extend and base-add logic.
`timescale 1ns / 1ps
module dep_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  dep_pkg::dep_item_t   item,
  input  logic                 short_absptr,
  output logic                 res_valid,
  output dep_pkg::dep_result_t result
);
  import dep_pkg::*;

  logic [ADDR_W-1:0]  accumulator, accumulator_next;
  logic [ADDR_W-1:0]  base_address, base_address_next;
  logic [SHIFT_W-1:0] bit_shift, bit_shift_next;
  logic [LEN_W-1:0]   byte_count, byte_count_next;
  logic [FMT_W-1:0]   value_format, value_format_next;
  logic               busy, busy_next;

  logic [FMT_W-1:0]   start_fmt;
  logic               known;
  logic               is_leb;
  logic [LEN_W-1:0]   fixed_n;
  logic [ADDR_W-1:0]  leb_acc;
  logic [SHIFT_W-1:0] leb_shift;
  logic [ADDR_W-1:0]  fix_acc;
  logic [LEN_W-1:0]   fix_count;
  logic [ADDR_W-1:0]  ext_value;
  logic               sign_bit;

  function automatic logic [LEN_W-1:0] fixed_size(input logic [FMT_W-1:0] fmt);
    logic [LEN_W-1:0] n;
    unique case (fmt)
      FMT_UDATA2, FMT_SDATA2: n = 4'd2;
      FMT_UDATA4, FMT_SDATA4: n = 4'd4;
      FMT_UDATA8, FMT_SDATA8: n = 4'd8;
      default:                n = 4'd0;
    endcase
    return n;
  endfunction

  always_comb begin
    accumulator_next  = accumulator;
    base_address_next = base_address;
    bit_shift_next    = bit_shift;
    byte_count_next   = byte_count;
    value_format_next = value_format;
    busy_next         = busy;
    res_valid         = 1'b0;
    result.value      = '0;
    result.length     = '0;
    result.bad_format = 1'b0;
    leb_acc           = '0;
    leb_shift         = '0;
    fix_acc           = '0;
    fix_count         = '0;
    ext_value         = '0;
    sign_bit          = 1'b0;

    start_fmt = item.encoding[FMT_W-1:0];
    if (start_fmt == FMT_ABSPTR) begin
      start_fmt = short_absptr ? FMT_UDATA4 : FMT_UDATA8;
    end
    known = (fixed_size(start_fmt) != '0) || (start_fmt == FMT_ULEB)
            || (start_fmt == FMT_SLEB);

    if (item.start_req) begin
      base_address_next = (item.encoding[6:4] == REL_PCREL) ? item.position : '0;
      if (!known) begin
        busy_next         = 1'b0;
        res_valid         = 1'b1;
        result.value      = base_address_next;
        result.bad_format = 1'b1;
      end else begin
        busy_next         = 1'b1;
        accumulator_next  = '0;
        bit_shift_next    = '0;
        byte_count_next   = '0;
        value_format_next = start_fmt;
      end
    end

    is_leb  = (value_format_next == FMT_ULEB) || (value_format_next == FMT_SLEB);
    fixed_n = fixed_size(value_format_next);

    if (busy_next) begin
      if (is_leb) begin
        leb_acc   = accumulator_next;
        leb_shift = bit_shift_next;
        if (bit_shift_next < SHIFT_W'(ADDR_W)) begin
          leb_acc   = leb_acc | (ADDR_W'(item.data_byte[6:0]) << bit_shift_next[5:0]);
          leb_shift = bit_shift_next + SHIFT_W'(7);
        end
        accumulator_next = leb_acc;
        bit_shift_next   = leb_shift;
        if (byte_count_next != 4'hf) begin
          byte_count_next = byte_count_next + 4'd1;
        end
        if (!item.data_byte[7]) begin
          if ((value_format_next == FMT_SLEB) && item.data_byte[6]
              && (leb_shift < SHIFT_W'(ADDR_W))) begin
            leb_acc = leb_acc | ({ADDR_W{1'b1}} << leb_shift[5:0]);
          end
          busy_next         = 1'b0;
          res_valid         = 1'b1;
          result.value      = base_address_next + leb_acc;
          result.length     = byte_count_next;
        end
      end else begin
        fix_acc = accumulator_next
                  | (ADDR_W'(item.data_byte) << {byte_count_next[2:0], 3'b000});
        fix_count        = byte_count_next + 4'd1;
        accumulator_next = fix_acc;
        byte_count_next  = fix_count;
        if (fix_count >= fixed_n) begin
          ext_value = fix_acc;
          sign_bit  = (fixed_n == 4'd2) ? fix_acc[15] : fix_acc[31];
          if (value_format_next[3] && (fixed_n != 4'd8) && sign_bit) begin
            if (fixed_n == 4'd2) begin
              ext_value[ADDR_W-1:16] = '1;
            end else begin
              ext_value[ADDR_W-1:32] = '1;
            end
          end
          busy_next     = 1'b0;
          res_valid     = 1'b1;
          result.value  = base_address_next + ext_value;
          result.length = fix_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      base_address <= '0;
      bit_shift    <= '0;
      byte_count   <= '0;
      value_format <= '0;
      busy         <= 1'b0;
    end else if (advance) begin
      accumulator  <= accumulator_next;
      base_address <= base_address_next;
      bit_shift    <= bit_shift_next;
      byte_count   <= byte_count_next;
      value_format <= value_format_next;
      busy         <= busy_next;
    end
  end

endmodule

// File: hdl/dep_out_reg.sv
// Result register that holds one decoded pointer until it is taken.
`timescale 1ns / 1ps
module dep_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  dep_pkg::dep_result_t result,
  output logic                 free,
  dep_ptr_if.source            ptr_out
);
  import dep_pkg::*;

  assign free = !ptr_out.valid || ptr_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_out.valid <= 1'b0;
    end else if (load) begin
      ptr_out.valid <= 1'b1;
    end else if (ptr_out.ready) begin
      ptr_out.valid <= 1'b0;
    end
    if (load) begin
      ptr_out.value      <= result.value;
      ptr_out.length     <= result.length;
      ptr_out.bad_format <= result.bad_format;
    end
  end

endmodule
